// ===== design/pbm_pkg.sv =====
package pbm_pkg;

   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned PROD_W  = 17;
   localparam int unsigned LANES   = 3;
   localparam int unsigned CSR_IDX_W = 4;

   localparam logic [2:0] MODE_MULTIPLY = 3'd0;
   localparam logic [2:0] MODE_SUBTRACT = 3'd1;
   localparam logic [2:0] MODE_SCREEN   = 3'd2;
   localparam logic [2:0] MODE_OVERLAY  = 3'd3;
   localparam logic [2:0] MODE_ADD      = 3'd4;
   localparam logic [2:0] MODE_SCALE    = 3'd5;
   localparam logic [2:0] MODE_COPY     = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_SELECT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADJUST_AMOUNT  = 4'd1;

   localparam logic [1:0] CHAN_BLUE  = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_RED   = 2'd2;
   localparam logic [1:0] CHAN_SPARE = 2'd3;

   // How a lane turns its stored product, or its stored pass value, into a channel value.
   typedef enum logic [1:0] {
      FIN_PASS = 2'd0,
      FIN_DIV  = 2'd1,
      FIN_INV  = 2'd2,
      FIN_SAT  = 2'd3
   } finish_type;

   typedef struct packed {
      logic [2:0]        mode;
      logic [CHAN_W-1:0] top_blue;
      logic [CHAN_W-1:0] top_green;
      logic [CHAN_W-1:0] top_red;
      logic [CHAN_W-1:0] bottom_blue;
      logic [CHAN_W-1:0] bottom_green;
      logic [CHAN_W-1:0] bottom_red;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_red;
   } rsp_type;

   typedef struct packed {
      logic              load;
      logic [2:0]        mode;
      logic              selected;
      logic [CHAN_W-1:0] amount;
   } lane_ctrl_type;

endpackage

// ===== design/pbm_lane.sv =====
module pbm_lane (
   input  logic                          clock,
   input  pbm_pkg::lane_ctrl_type        ctrl,
   input  logic [pbm_pkg::CHAN_W-1:0]    top,
   input  logic [pbm_pkg::CHAN_W-1:0]    bottom,
   output logic [pbm_pkg::CHAN_W-1:0]    result
);

   localparam int unsigned W = pbm_pkg::CHAN_W;
   localparam int unsigned PW = pbm_pkg::PROD_W;

   logic [W-1:0]        op_a;
   logic [W-1:0]        op_b;
   logic                dbl;
   logic [2*W-1:0]      mult;
   logic [W:0]          sum;
   logic [PW-1:0]       prod_in;
   logic [PW-1:0]       prod_ff;
   logic [W-1:0]        pass_in;
   logic [W-1:0]        pass_ff;
   pbm_pkg::finish_type fin_in;
   pbm_pkg::finish_type fin_ff;

   logic [PW:0]         x;
   logic [PW:0]         x_sum;
   logic [PW-W:0]       q_est;
   logic [PW:0]         r;
   logic [PW-W:0]       q;

   assign sum = {1'b0, top} + {1'b0, ctrl.amount};

   always_comb begin
      op_a    = top;
      op_b    = bottom;
      dbl     = 1'b0;
      pass_in = '0;
      fin_in  = pbm_pkg::FIN_PASS;
      unique case (ctrl.mode)
         pbm_pkg::MODE_MULTIPLY: begin
            fin_in = pbm_pkg::FIN_DIV;
         end
         pbm_pkg::MODE_SUBTRACT: begin
            pass_in = (bottom > top) ? bottom - top : '0;
         end
         pbm_pkg::MODE_SCREEN: begin
            op_a   = ~top;
            op_b   = ~bottom;
            fin_in = pbm_pkg::FIN_INV;
         end
         pbm_pkg::MODE_OVERLAY: begin
            dbl = 1'b1;
            if (bottom[W-1]) begin
               op_a   = ~top;
               op_b   = ~bottom;
               fin_in = pbm_pkg::FIN_INV;
            end else begin
               fin_in = pbm_pkg::FIN_DIV;
            end
         end
         pbm_pkg::MODE_ADD: begin
            if (ctrl.selected) begin
               pass_in = sum[W] ? '1 : sum[W-1:0];
            end else begin
               pass_in = top;
            end
         end
         pbm_pkg::MODE_SCALE: begin
            op_b    = ctrl.amount;
            pass_in = top;
            if (ctrl.selected) begin
               fin_in = pbm_pkg::FIN_SAT;
            end
         end
         pbm_pkg::MODE_COPY: begin
            pass_in = top;
         end
         default: begin
            pass_in = '0;
         end
      endcase
   end

   assign mult    = op_a * op_b;
   assign prod_in = dbl ? {mult, 1'b0} : {1'b0, mult};

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_ff <= prod_in;
         pass_ff <= pass_in;
         fin_ff  <= fin_in;
      end
   end

   // Rounded divide by 255: round(p/255) is floor((p+127)/255). The estimate
   // (x + x/256)/256 is low by at most one, so one compare corrects it.
   assign x     = {1'b0, prod_ff} + (PW+1)'(127);
   assign x_sum = x + (x >> W);
   assign q_est = x_sum[PW:W];
   assign r     = x - (({{(W-1){1'b0}}, q_est} << W) - {{(W-1){1'b0}}, q_est});
   assign q     = (r >= (PW+1)'(255)) ? q_est + 1'b1 : q_est;

   always_comb begin
      unique case (fin_ff)
         pbm_pkg::FIN_PASS: result = pass_ff;
         pbm_pkg::FIN_DIV:  result = q[W-1:0];
         pbm_pkg::FIN_INV:  result = ~q[W-1:0];
         pbm_pkg::FIN_SAT:  result = (prod_ff > PW'(255)) ? '1 : prod_ff[W-1:0];
         default:           result = '0;
      endcase
   end

endmodule

// ===== design/pbm_merge.sv =====
module pbm_merge (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   input  logic [2:0]                                mode,
   input  logic [pbm_pkg::CHAN_W-1:0]                copy_value,
   input  logic [pbm_pkg::LANES-1:0][pbm_pkg::CHAN_W-1:0] lane_result,
   input  logic                                      rsp_stall,
   output logic                                      advance,
   output logic                                      rsp_valid,
   output pbm_pkg::rsp_type                          rsp_data
);

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   pbm_pkg::rsp_type rsp_data_ff;
   pbm_pkg::rsp_type rsp_data_in;

   // The output register takes a new pixel whenever it is empty or its
   // pixel leaves in this cycle.
   assign advance = in_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (mode == pbm_pkg::MODE_COPY) begin
         rsp_data_in.out_blue  = copy_value;
         rsp_data_in.out_green = copy_value;
         rsp_data_in.out_red   = copy_value;
      end else begin
         rsp_data_in.out_blue  = lane_result[pbm_pkg::CHAN_BLUE];
         rsp_data_in.out_green = lane_result[pbm_pkg::CHAN_GREEN];
         rsp_data_in.out_red   = lane_result[pbm_pkg::CHAN_RED];
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/pixel_blend_modes.sv =====
// Pixel blender: combines one top and one bottom BGR pixel into one pixel.
//
// Input channel req_valid / req_stall / req_data carries the mode and both
// pixels; a transfer happens at a clock edge with valid high and stall low.
// Result channel rsp_valid / rsp_stall / rsp_data carries the blended pixel
// under the same rule. The csr_ write channel sets channel_select (index 0)
// and adjust_amount (index 1); it is always ready and should be written only
// while no pixel is in flight.
//
// Three channel lanes run side by side: the lane stage registers one 8x8
// product or pass value per lane, which is divided by 255 with rounding,
// saturated or passed on the way to a merge stage that registers the pixel.
// One pixel is taken every cycle while the receiver keeps up.
//
// When the receiver stalls, the output register holds its pixel, one more
// pixel waits in the lane stage, and then req_stall rises until the output
// moves. Synchronous reset empties the pipeline and clears both csr registers.
module pixel_blend_modes (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pbm_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pbm_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pbm_pkg::CHAN_W-1:0]       csr_data
);

   localparam int unsigned W = pbm_pkg::CHAN_W;

   logic [1:0]   channel_select_ff;
   logic [W-1:0] adjust_amount_ff;
   logic [1:0]   sel;

   logic         s1_valid_ff;
   logic         s1_valid_in;
   logic [2:0]   s1_mode_ff;
   logic [W-1:0] s1_copy_ff;
   logic [W-1:0] top_sel;
   logic         accept;
   logic         advance;

   logic [pbm_pkg::LANES-1:0][W-1:0] top;
   logic [pbm_pkg::LANES-1:0][W-1:0] bottom;
   logic [pbm_pkg::LANES-1:0][W-1:0] lane_result;
   pbm_pkg::lane_ctrl_type           lane_ctrl [pbm_pkg::LANES];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_select_ff <= pbm_pkg::CHAN_BLUE;
         adjust_amount_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == pbm_pkg::CSR_CHANNEL_SELECT) begin
            channel_select_ff <= csr_data[1:0];
         end else if (csr_index == pbm_pkg::CSR_ADJUST_AMOUNT) begin
            adjust_amount_ff <= csr_data;
         end
      end
   end

   // The unused channel code selects red.
   assign sel = (channel_select_ff == pbm_pkg::CHAN_SPARE) ? pbm_pkg::CHAN_RED
                                                           : channel_select_ff;

   assign top[pbm_pkg::CHAN_BLUE]     = req_data.top_blue;
   assign top[pbm_pkg::CHAN_GREEN]    = req_data.top_green;
   assign top[pbm_pkg::CHAN_RED]      = req_data.top_red;
   assign bottom[pbm_pkg::CHAN_BLUE]  = req_data.bottom_blue;
   assign bottom[pbm_pkg::CHAN_GREEN] = req_data.bottom_green;
   assign bottom[pbm_pkg::CHAN_RED]   = req_data.bottom_red;
   assign top_sel = top[sel];

   assign req_stall   = s1_valid_ff && rsp_valid && rsp_stall;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff <= req_data.mode;
         s1_copy_ff <= top_sel;
      end
   end

   for (genvar i = 0; i < pbm_pkg::LANES; i++) begin : g_lane
      assign lane_ctrl[i].load     = accept;
      assign lane_ctrl[i].mode     = req_data.mode;
      assign lane_ctrl[i].selected = (sel == 2'(i));
      assign lane_ctrl[i].amount   = adjust_amount_ff;

      pbm_lane u_lane (
         .clock  (clock),
         .ctrl   (lane_ctrl[i]),
         .top    (top[i]),
         .bottom (bottom[i]),
         .result (lane_result[i])
      );
   end

   pbm_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid_ff),
      .mode        (s1_mode_ff),
      .copy_value  (s1_copy_ff),
      .lane_result (lane_result),
      .rsp_stall   (rsp_stall),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the pipeline has room");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted pixel did not reach the lane stage");

   a_stage_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_stall) |=> rsp_valid)
      else $error("pixel in the lane stage did not reach the output");

   a_no_duplicate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !s1_valid_ff) |=> !rsp_valid)
      else $error("result repeated after its transfer");

endmodule

// ===== tb/tb_pixel_blend_modes.sv =====
`timescale 1ns / 1ps

module tb_pixel_blend_modes;

   localparam logic [2:0] MODE_UNUSED = 3'd7;
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_PER_PHASE = 200;
   localparam int CONFIG_PHASES = 9;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   pbm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   pbm_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pbm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pbm_pkg::CHAN_W-1:0] csr_data = '0;

   // Copies of the block's registers, updated when a write transfer completes.
   logic [1:0] chan_sel_copy = pbm_pkg::CHAN_BLUE;
   logic [pbm_pkg::CHAN_W-1:0] amount_copy = '0;

   pbm_pkg::req_type pending_pixels[$];
   pbm_pkg::rsp_type expected_pixels[$];
   pbm_pkg::rsp_type want_pixel;
   int send_idle_pct = 30;
   int recv_stall_pct = 30;
   int send_gap_left = 0;
   int recv_stall_left = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   pixel_blend_modes dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   function automatic logic [pbm_pkg::CHAN_W-1:0] round_div255(input int unsigned x);
      return 8'((2 * x + 255) / 510);
   endfunction

   function automatic logic [pbm_pkg::CHAN_W-1:0] blend_lane(input logic [2:0] mode,
                                                             input int unsigned t,
                                                             input int unsigned b);
      case (mode)
         pbm_pkg::MODE_MULTIPLY: return round_div255(t * b);
         pbm_pkg::MODE_SUBTRACT: return (b > t) ? 8'(b - t) : 8'd0;
         pbm_pkg::MODE_SCREEN:   return 8'(255 - round_div255((255 - t) * (255 - b)));
         pbm_pkg::MODE_OVERLAY: begin
            if (b <= 127)
               return round_div255(2 * t * b);
            return 8'(255 - round_div255(2 * (255 - t) * (255 - b)));
         end
         default:       return 8'd0;
      endcase
   endfunction

   function automatic pbm_pkg::rsp_type blend_pixel(input pbm_pkg::req_type r,
                                                    input logic [1:0] sel_code,
                                                    input logic [pbm_pkg::CHAN_W-1:0] amount);
      logic [pbm_pkg::CHAN_W-1:0] top[3];
      logic [pbm_pkg::CHAN_W-1:0] bot[3];
      logic [pbm_pkg::CHAN_W-1:0] res[3];
      int unsigned sel;
      int unsigned wide;
      pbm_pkg::rsp_type p;
      top = '{r.top_blue, r.top_green, r.top_red};
      bot = '{r.bottom_blue, r.bottom_green, r.bottom_red};
      // The spare channel code behaves like red.
      sel = (sel_code == pbm_pkg::CHAN_SPARE) ? 32'(pbm_pkg::CHAN_RED) : 32'(sel_code);
      case (r.mode)
         pbm_pkg::MODE_MULTIPLY, pbm_pkg::MODE_SUBTRACT,
         pbm_pkg::MODE_SCREEN, pbm_pkg::MODE_OVERLAY: begin
            for (int i = 0; i < 3; i++)
               res[i] = blend_lane(r.mode, 32'(top[i]), 32'(bot[i]));
         end
         pbm_pkg::MODE_ADD: begin
            res = top;
            wide = int'(top[sel]) + int'(amount);
            res[sel] = (wide > 255) ? 8'd255 : 8'(wide);
         end
         pbm_pkg::MODE_SCALE: begin
            res = top;
            wide = int'(top[sel]) * int'(amount);
            res[sel] = (wide > 255) ? 8'd255 : 8'(wide);
         end
         pbm_pkg::MODE_COPY: begin
            for (int i = 0; i < 3; i++)
               res[i] = top[sel];
         end
         default: begin
            res = '{8'd0, 8'd0, 8'd0};
         end
      endcase
      p.out_blue = res[0];
      p.out_green = res[1];
      p.out_red = res[2];
      return p;
   endfunction

   // No gap unless a draw falls below idle_pct; a gap is mostly short, now and then long.
   function automatic int pick_gap(input int idle_pct);
      if ($urandom_range(0, 99) >= idle_pct)
         return 0;
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [pbm_pkg::CHAN_W-1:0] pick_channel();
      case ($urandom_range(0, 15))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd127;
         3: return 8'd128;
         4: return 8'($urandom_range(0, 3));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pbm_pkg::req_type make_pixel(input logic [2:0] mode,
                                                   input logic [pbm_pkg::CHAN_W-1:0] tb, tg,
                                                   input logic [pbm_pkg::CHAN_W-1:0] tr, bb,
                                                   input logic [pbm_pkg::CHAN_W-1:0] bg, br);
      pbm_pkg::req_type r;
      r.mode = mode;
      r.top_blue = tb;
      r.top_green = tg;
      r.top_red = tr;
      r.bottom_blue = bb;
      r.bottom_green = bg;
      r.bottom_red = br;
      return r;
   endfunction

   function automatic pbm_pkg::req_type random_pixel();
      return make_pixel(3'($urandom_range(pbm_pkg::MODE_MULTIPLY, MODE_UNUSED)),
                        pick_channel(), pick_channel(), pick_channel(),
                        pick_channel(), pick_channel(), pick_channel());
   endfunction

   task automatic add_pending(input pbm_pkg::req_type r);
      pending_pixels = {pending_pixels, r};
   endtask

   task automatic report_mismatch(input string what, input pbm_pkg::rsp_type want,
                                  input pbm_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s at %0t: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                  what, $realtime, want.out_blue, want.out_green, want.out_red,
                  got.out_blue, got.out_green, got.out_red);
   endtask

   task automatic write_csr(input logic [pbm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pbm_pkg::CHAN_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == pbm_pkg::CSR_CHANNEL_SELECT)
         chan_sel_copy = value[1:0];
      else if (idx == pbm_pkg::CSR_ADJUST_AMOUNT)
         amount_copy = value;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(negedge clock);
   endtask

   // Driver: one transfer per cycle at most, with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap_left = 0;
      end else begin
         if (req_valid && !req_stall)
            expected_pixels = {expected_pixels,
                               blend_pixel(req_data, chan_sel_copy, amount_copy)};
         if (req_valid && req_stall) begin
            // Stalled: keep the payload as it is.
         end else if (send_gap_left > 0) begin
            req_valid <= 1'b0;
            send_gap_left--;
         end else if (pending_pixels.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= pending_pixels.pop_front();
            send_gap_left = pick_gap(send_idle_pct);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks every result transfer against the oldest expected pixel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("with nothing expected", '0, rsp_data);
            end else begin
               want_pixel = expected_pixels.pop_front();
               if (rsp_data.out_blue !== want_pixel.out_blue)
                  report_mismatch("in out_blue", want_pixel, rsp_data);
               if (rsp_data.out_green !== want_pixel.out_green)
                  report_mismatch("in out_green", want_pixel, rsp_data);
               if (rsp_data.out_red !== want_pixel.out_red)
                  report_mismatch("in out_red", want_pixel, rsp_data);
            end
         end
         if (recv_stall_left > 0) begin
            rsp_stall <= 1'b1;
            recv_stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            recv_stall_left = pick_gap(recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [1:0] sel_plan[CONFIG_PHASES];
      logic [pbm_pkg::CHAN_W-1:0] amount_plan[CONFIG_PHASES];
      sel_plan = '{pbm_pkg::CHAN_GREEN, pbm_pkg::CHAN_RED, pbm_pkg::CHAN_SPARE,
                   pbm_pkg::CHAN_BLUE, pbm_pkg::CHAN_RED, pbm_pkg::CHAN_BLUE,
                   pbm_pkg::CHAN_GREEN, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))};
      amount_plan = '{8'd255, 8'd1, 8'd128, 8'd0, 8'd255, 8'd1, 8'd2,
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Register reset values: every mode on zero, full scale and mixed pixels,
      // plus the overlay switch point between bottom 127 and 128.
      for (int m = pbm_pkg::MODE_MULTIPLY; m <= MODE_UNUSED; m++) begin
         add_pending(make_pixel(3'(m), 0, 0, 0, 0, 0, 0));
         add_pending(make_pixel(3'(m), 255, 255, 255, 255, 255, 255));
         add_pending(make_pixel(3'(m), 0, 128, 255, 255, 127, 128));
      end
      add_pending(make_pixel(pbm_pkg::MODE_OVERLAY, 200, 200, 200, 127, 128, 0));
      repeat (50) add_pending(random_pixel());
      wait_drained();

      for (int ph = 0; ph < CONFIG_PHASES; ph++) begin
         // The upper bits of the select write are ignored by the block.
         write_csr(pbm_pkg::CSR_CHANNEL_SELECT, {6'($urandom_range(0, 63)), sel_plan[ph]});
         write_csr(pbm_pkg::CSR_ADJUST_AMOUNT, amount_plan[ph]);
         @(negedge clock);
         if (ph % 3 == 0) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end else begin
            send_idle_pct = $urandom_range(0, 1) ? 25 : 60;
            recv_stall_pct = $urandom_range(0, 1) ? 25 : 60;
         end
         repeat (RANDOM_PER_PHASE) add_pending(random_pixel());
         wait_drained();
      end

      repeat (6) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/pbm_pkg.sv
design/pbm_lane.sv
design/pbm_merge.sv
design/pixel_blend_modes.sv
tb/tb_pixel_blend_modes.sv
